// ----- hdl/npg_pkg.sv -----
// shared types and constants for the next permutation generator
package npg_pkg;

	localparam int ELEM_W  = 16;
	localparam int IDX_W   = 4;
	localparam int SEG_W   = 5;
	localparam int MAX_RUN = 16;

	localparam logic [1:0] CMD_IDENT   = 2'd0;
	localparam logic [1:0] CMD_WRITE   = 2'd1;
	localparam logic [1:0] CMD_ADVANCE = 2'd2;
	localparam logic [1:0] CMD_UNUSED  = 2'd3;

	localparam logic [0:0] REG_SEG_START = 1'b0;
	localparam logic [0:0] REG_SEG_END   = 1'b1;

	// datapath operations issued by the controller
	typedef enum logic [3:0] {
		OP_NONE   = 4'd0,
		OP_IDENT  = 4'd1,
		OP_WRITE  = 4'd2,
		OP_PSETUP = 4'd3,  // begin a pivot: pivot = p-1, scan from pivot+1
		OP_SCAN   = 4'd4,  // compare one suffix element with the pivot
		OP_SWAP   = 4'd5,
		OP_ISETUP = 4'd6,  // begin an insertion pass for element i
		OP_ISTEP  = 4'd7,  // one shift step of insertion sort
		OP_EMIT   = 4'd8,
		OP_START  = 4'd9   // prime the pivot and run counters for an advance
	} op_t;

	typedef struct packed {
		op_t op;
	} npg_cmd_t;

	typedef struct packed {
		logic no_pivot;   // segment too short
		logic pivot_done; // p reached lo
		logic scan_done;  // scan index reached hi
		logic found;
		logic sort_done;  // insertion index reached hi
		logic ins_done;   // current insertion pass finished
		logic emit_last;
	} npg_stat_t;

endpackage

// ----- hdl/npg_datapath.sv -----
// element store, scan and insertion sort datapath
module npg_datapath #(
	parameter int VEC_LEN = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  npg_pkg::npg_cmd_t         cmd_i,
	output npg_pkg::npg_stat_t        stat_o,
	input  logic [npg_pkg::SEG_W-1:0] seg_start_i,
	input  logic [npg_pkg::SEG_W-1:0] seg_end_i,
	input  logic [3:0]                elem_index_i,
	input  logic [npg_pkg::ELEM_W-1:0] elem_value_i,
	output logic [npg_pkg::IDX_W-1:0] emit_index_o,
	output logic [npg_pkg::ELEM_W-1:0] emit_value_o
);
	localparam int AW = (VEC_LEN > 1) ? $clog2(VEC_LEN) : 1;
	localparam int CW = $clog2(VEC_LEN + 1);
	localparam int RUN = (VEC_LEN < npg_pkg::MAX_RUN) ? VEC_LEN : npg_pkg::MAX_RUN;

	logic [npg_pkg::ELEM_W-1:0] vec_q [VEC_LEN];
	logic [CW-1:0] hi, lo;
	logic [CW-1:0] p_q, piv_q, i_q, j_q, bi_q, k_q;
	logic [npg_pkg::ELEM_W-1:0] cur_q, best_q, key_q;
	logic found_q;
	logic [npg_pkg::ELEM_W-1:0] e_i, e_jm1;

	always_comb begin
		if (int'(seg_end_i) > VEC_LEN) hi = CW'(VEC_LEN);
		else hi = CW'(seg_end_i);
		if (int'(seg_start_i) > VEC_LEN) lo = CW'(VEC_LEN);
		else lo = CW'(seg_start_i);
	end

	assign e_i   = vec_q[i_q[AW-1:0]];
	assign e_jm1 = vec_q[AW'(j_q - CW'(1))];

	always_comb begin
		stat_o.no_pivot   = (hi < CW'(2)) || ({1'b0, lo} + (CW+1)'(2) > {1'b0, hi});
		stat_o.pivot_done = (p_q <= lo);
		stat_o.scan_done  = (i_q >= hi);
		stat_o.found      = found_q;
		stat_o.sort_done  = (i_q >= hi);
		stat_o.ins_done   = !((j_q > piv_q + CW'(1)) && (e_jm1 > key_q));
		stat_o.emit_last  = (k_q == CW'(RUN - 1));
	end

	assign emit_index_o = k_q[npg_pkg::IDX_W-1:0];
	assign emit_value_o = vec_q[k_q[AW-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q <= '0; piv_q <= '0; i_q <= '0; j_q <= '0; bi_q <= '0; k_q <= '0;
			cur_q <= '0; best_q <= '0; key_q <= '0;
			found_q <= 1'b0;
		end else begin
			case (cmd_i.op)
				npg_pkg::OP_IDENT: begin
					k_q <= '0;
				end
				npg_pkg::OP_WRITE: begin
					k_q <= '0;
				end
				npg_pkg::OP_START: begin
					p_q <= hi - CW'(1);
					k_q <= '0;
				end
				npg_pkg::OP_PSETUP: begin
					piv_q <= p_q - CW'(1);
					i_q <= p_q;
					cur_q <= vec_q[AW'(p_q - CW'(1))];
					found_q <= 1'b0;
				end
				npg_pkg::OP_SCAN: begin
					if (e_i > cur_q && (!found_q || e_i < best_q)) begin
						best_q <= e_i; bi_q <= i_q; found_q <= 1'b1;
					end
					i_q <= i_q + CW'(1);
					if (i_q + CW'(1) >= hi && !(e_i > cur_q && (!found_q || e_i < best_q))
					    && !found_q)
						p_q <= p_q - CW'(1);
				end
				npg_pkg::OP_SWAP: begin
					i_q <= piv_q + CW'(2);
				end
				npg_pkg::OP_ISETUP: begin
					key_q <= e_i;
					j_q <= i_q;
				end
				npg_pkg::OP_ISTEP: begin
					if (stat_o.ins_done) i_q <= i_q + CW'(1);
					else j_q <= j_q - CW'(1);
				end
				npg_pkg::OP_EMIT: begin
					k_q <= k_q + CW'(1);
				end
				default: begin
				end
			endcase
		end
	end

	// element store writes
	always_ff @(posedge clk) begin
		case (cmd_i.op)
			npg_pkg::OP_IDENT: begin
				for (int n = 0; n < VEC_LEN; n++) vec_q[n] <= npg_pkg::ELEM_W'(n);
			end
			npg_pkg::OP_WRITE: begin
				if (int'(elem_index_i) < VEC_LEN)
					vec_q[AW'(elem_index_i)] <= elem_value_i;
			end
			npg_pkg::OP_SWAP: begin
				vec_q[bi_q[AW-1:0]]  <= cur_q;
				vec_q[piv_q[AW-1:0]] <= best_q;
			end
			npg_pkg::OP_ISTEP: begin
				if (stat_o.ins_done) vec_q[j_q[AW-1:0]] <= key_q;
				else vec_q[j_q[AW-1:0]] <= e_jm1;
			end
			default: begin
			end
		endcase
	end
endmodule

// ----- hdl/npg_ctrl.sv -----
// controller state machine for the next permutation generator
module npg_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         cmd,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               ok_o,
	input  npg_pkg::npg_stat_t stat_i,
	output npg_pkg::npg_cmd_t  cmd_o
);
	typedef enum logic [7:0] {
		S_IDLE  = 8'b00000001,
		S_PSET  = 8'b00000010,
		S_SCAN  = 8'b00000100,
		S_SWAP  = 8'b00001000,
		S_ISET  = 8'b00010000,
		S_ISTEP = 8'b00100000,
		S_EMIT  = 8'b01000000,
		S_PCHK  = 8'b10000000
	} state_t;

	state_t state_q, state_d;
	logic ok_q, ok_d;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_EMIT);
	assign ok_o      = ok_q;

	always_comb begin
		state_d = state_q;
		ok_d = ok_q;
		cmd_o.op = npg_pkg::OP_NONE;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (cmd)
						npg_pkg::CMD_IDENT: begin
							cmd_o.op = npg_pkg::OP_IDENT; ok_d = 1'b1; state_d = S_EMIT;
						end
						npg_pkg::CMD_WRITE: cmd_o.op = npg_pkg::OP_WRITE;
						npg_pkg::CMD_ADVANCE: begin
							cmd_o.op = npg_pkg::OP_START;
							if (stat_i.no_pivot) begin
								ok_d = 1'b0; state_d = S_EMIT;
							end else state_d = S_PSET;
						end
						default: ;
					endcase
				end
			end
			S_PCHK: begin
				if (stat_i.pivot_done) begin
					ok_d = 1'b0; state_d = S_EMIT;
				end else state_d = S_PSET;
			end
			S_PSET: begin
				cmd_o.op = npg_pkg::OP_PSETUP; state_d = S_SCAN;
			end
			S_SCAN: begin
				if (stat_i.scan_done) begin
					state_d = stat_i.found ? S_SWAP : S_PCHK;
				end else cmd_o.op = npg_pkg::OP_SCAN;
				if (!stat_i.scan_done) state_d = S_SCAN;
			end
			S_SWAP: begin
				cmd_o.op = npg_pkg::OP_SWAP; ok_d = 1'b1; state_d = S_ISET;
			end
			S_ISET: begin
				if (stat_i.sort_done) state_d = S_EMIT;
				else begin
					cmd_o.op = npg_pkg::OP_ISETUP; state_d = S_ISTEP;
				end
			end
			S_ISTEP: begin
				cmd_o.op = npg_pkg::OP_ISTEP;
				if (stat_i.ins_done) state_d = S_ISET;
			end
			S_EMIT: begin
				if (!out_stall) begin
					cmd_o.op = npg_pkg::OP_EMIT;
					if (stat_i.emit_last) state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ok_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ok_q <= ok_d;
		end
	end
endmodule

// ----- hdl/next_permutation_generator.sv -----
// top level of the next permutation generator
// usage:
//   input channel in_valid/in_stall carries cmd, elem_index, elem_value.
//   cmd 0 loads the identity, 1 writes one element (no results), 2 steps
//   the segment [seg_start, seg_end) to its lexicographic successor.
//   load and advance emit min(VEC_LEN,16) result transactions on
//   out_valid/out_stall, out_index ascending, last high on the final one.
//   advanced is 1 after a load or successful advance, 0 after a failed advance; a write leaves it unchanged.
//   one item is worked at a time: in_stall is high until its run is out.
//   an advance, for each pivot tried, scans the suffix with the single
//   compare unit one element at a time, then insertion-sorts the suffix one
//   shift at a time (quadratic in suffix length worst case), then the run.
//   a write does not stall the input; a load sets the identity, then the run.
//   the run is paced by out_stall, one element per unstalled cycle.
//   configuration writes via cfg_we/cfg_index/cfg_data while idle.
//   reset sets seg_start 0, seg_end 16; the element store is undefined
//   until loaded or written.
module next_permutation_generator #(
	parameter int VEC_LEN = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [3:0]  elem_index,
	input  logic [15:0] elem_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  out_index,
	output logic [15:0] out_value,
	output logic        advanced,
	output logic        last,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [4:0]  cfg_data
);
	logic [npg_pkg::SEG_W-1:0] seg_start_q, seg_end_q;
	npg_pkg::npg_cmd_t  dp_cmd;
	npg_pkg::npg_stat_t dp_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_start_q <= 5'd0;
			seg_end_q   <= 5'd16;
		end else if (cfg_we) begin
			case (cfg_index)
				npg_pkg::REG_SEG_START: seg_start_q <= cfg_data;
				npg_pkg::REG_SEG_END:   seg_end_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	npg_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .out_valid(out_valid), .out_stall(out_stall), .ok_o(advanced),
		.stat_i(dp_stat), .cmd_o(dp_cmd)
	);

	npg_datapath #(.VEC_LEN(VEC_LEN)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd_i(dp_cmd), .stat_o(dp_stat),
		.seg_start_i(seg_start_q), .seg_end_i(seg_end_q),
		.elem_index_i(elem_index), .elem_value_i(elem_value),
		.emit_index_o(out_index), .emit_value_o(out_value)
	);

	assign last = dp_stat.emit_last;
endmodule

// ----- test/next_permutation_generator_tb.sv -----
// testbench for the next permutation generator: random commands, predicted vector runs
`timescale 1ns / 1ps

module next_permutation_generator_tb;

	localparam int VLEN = 16;
	localparam int WATCHDOG = 20000;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [3:0]  idx;
		logic [15:0] val;
	} perm_cmd_t;

	typedef struct packed {
		logic [3:0]  idx;
		logic [15:0] val;
		logic        adv;
		logic        lst;
	} elem_out_t;

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, out_stall = 0;
	logic [1:0] cmd = 0;
	logic [3:0] elem_index = 0;
	logic [15:0] elem_value = 0;
	logic cfg_we = 0, cfg_index = 0;
	logic [4:0] cfg_data = 0;
	logic in_stall, out_valid, advanced, last;
	logic [3:0] out_index;
	logic [15:0] out_value;

	next_permutation_generator dut (.*);

	initial forever #2 clk = ~clk;

	perm_cmd_t pending_cmds[$];
	elem_out_t expected_elems[$];
	logic [15:0] vec_model[VLEN];
	logic [4:0] seg_lo = 0, seg_hi = 16;
	int errors = 0;
	int idle_cycles = 0;
	int send_gap = 0, stall_gap = 0;
	bit holding = 0;
	logic in_stall_q = 1;

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// next lexicographic successor within the segment, returns success
	function automatic bit step_segment();
		int hi, lo, piv, bi, j;
		logic [15:0] best, cur, key;
		bit found;
		hi = (seg_hi > VLEN) ? VLEN : seg_hi;
		lo = seg_lo;
		if (hi < 2 || lo + 2 > hi) return 1'b0;
		for (piv = hi - 2; piv >= lo; piv--) begin
			cur = vec_model[piv];
			found = 0;
			best = 0;
			bi = 0;
			for (int i = piv + 1; i < hi; i++)
				if (vec_model[i] > cur && (!found || vec_model[i] < best)) begin
					best = vec_model[i];
					bi = i;
					found = 1;
				end
			if (found) begin
				vec_model[bi] = cur;
				vec_model[piv] = best;
				for (int i = piv + 2; i < hi; i++) begin
					key = vec_model[i];
					j = i;
					while (j > piv + 1 && vec_model[j-1] > key) begin
						vec_model[j] = vec_model[j-1];
						j--;
					end
					vec_model[j] = key;
				end
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	task automatic predict_cmd(perm_cmd_t c);
		bit ok;
		elem_out_t e;
		if (c.cmd == npg_pkg::CMD_WRITE) begin
			vec_model[c.idx] = c.val;
			return;
		end
		if (c.cmd == npg_pkg::CMD_IDENT) begin
			for (int i = 0; i < VLEN; i++) vec_model[i] = 16'(i);
			ok = 1;
		end else if (c.cmd == npg_pkg::CMD_ADVANCE) begin
			ok = step_segment();
		end else begin
			return;
		end
		for (int k = 0; k < VLEN; k++) begin
			e.idx = 4'(k);
			e.val = vec_model[k];
			e.adv = ok;
			e.lst = (k == VLEN - 1);
			expected_elems.push_back(e);
		end
	endtask

	// driver
	always @(negedge clk) begin
		if (arst_n && !holding) begin
			if (in_valid && !in_stall_q) begin
				in_valid <= 0;
				send_gap = gap_len();
			end else if (!in_valid && pending_cmds.size() > 0) begin
				if (send_gap > 0) send_gap--;
				else begin
					cmd <= pending_cmds[0].cmd;
					elem_index <= pending_cmds[0].idx;
					elem_value <= pending_cmds[0].val;
					in_valid <= 1;
				end
			end
		end
		if (arst_n) begin
			if (stall_gap > 0) begin
				out_stall <= 1;
				stall_gap--;
			end else begin
				out_stall <= 0;
				if ($urandom_range(0, 9) == 0) stall_gap = gap_len();
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		in_stall_q <= !(arst_n && in_valid && !in_stall);
		idle_cycles++;
		if (arst_n && in_valid && !in_stall) begin
			predict_cmd(pending_cmds.pop_front());
			idle_cycles = 0;
		end
		if (arst_n && out_valid && !out_stall) begin
			idle_cycles = 0;
			if (expected_elems.size() == 0) begin
				$error("unexpected result index %0d", out_index);
				errors++;
			end else begin
				elem_out_t e;
				e = expected_elems.pop_front();
				if (out_index !== e.idx) begin
					$error("out_index exp %0d got %0d", e.idx, out_index); errors++;
				end
				if (out_value !== e.val) begin
					$error("out_value exp %0h got %0h", e.val, out_value); errors++;
				end
				if (advanced !== e.adv) begin
					$error("advanced exp %0d got %0d", e.adv, advanced); errors++;
				end
				if (last !== e.lst) begin
					$error("last exp %0d got %0d", e.lst, last); errors++;
				end
			end
		end
		if (idle_cycles >= WATCHDOG) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic add_cmd(logic [1:0] c, logic [3:0] i, logic [15:0] v);
		perm_cmd_t p;
		p.cmd = c;
		p.idx = i;
		p.val = v;
		pending_cmds.push_back(p);
	endtask

	task automatic drain();
		while (pending_cmds.size() > 0 || in_valid || expected_elems.size() > 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_seg(logic [4:0] lo, logic [4:0] hi);
		@(negedge clk);
		cfg_we <= 1; cfg_index <= npg_pkg::REG_SEG_START; cfg_data <= lo;
		@(negedge clk);
		cfg_index <= npg_pkg::REG_SEG_END; cfg_data <= hi;
		@(negedge clk);
		cfg_we <= 0;
		seg_lo = lo;
		seg_hi = hi;
	endtask

	// random loads, writes, unused commands and advances; writes hit defined positions, keeping the store initialized
	task automatic random_phase(int n);
		int r;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			if (r < 8) add_cmd(npg_pkg::CMD_IDENT, 4'($urandom), 16'($urandom));
			else if (r < 30) begin
				case ($urandom_range(0, 2))
					0: add_cmd(npg_pkg::CMD_WRITE, 4'($urandom), 16'hffff);
					1: add_cmd(npg_pkg::CMD_WRITE, 4'($urandom), 16'($urandom_range(0, 7)));
					default: add_cmd(npg_pkg::CMD_WRITE, 4'($urandom), 16'($urandom));
				endcase
			end else if (r < 33) add_cmd(npg_pkg::CMD_UNUSED, 4'($urandom), 16'($urandom));
			else add_cmd(npg_pkg::CMD_ADVANCE, 4'($urandom), 16'($urandom));
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		// directed: identity, extremes, unused command, full-order successors
		add_cmd(npg_pkg::CMD_IDENT, 4'hf, 16'hffff);
		add_cmd(npg_pkg::CMD_UNUSED, 4'h0, 16'h0);
		add_cmd(npg_pkg::CMD_ADVANCE, 4'd0, 16'd0);
		add_cmd(npg_pkg::CMD_WRITE, 4'd15, 16'hffff);
		add_cmd(npg_pkg::CMD_WRITE, 4'd0, 16'hffff);
		add_cmd(npg_pkg::CMD_ADVANCE, 4'd0, 16'd0);
		add_cmd(npg_pkg::CMD_WRITE, 4'd7, 16'h0000);
		add_cmd(npg_pkg::CMD_ADVANCE, 4'd0, 16'd0);
		drain();
		write_seg(5'd12, 5'd31);
		add_cmd(npg_pkg::CMD_IDENT, 4'd0, 16'd0);
		for (int i = 0; i < 6; i++) add_cmd(npg_pkg::CMD_ADVANCE, 4'd0, 16'd0);
		for (int i = 12; i < 16; i++) add_cmd(npg_pkg::CMD_WRITE, 4'(i), 16'(20 - i));
		add_cmd(npg_pkg::CMD_ADVANCE, 4'd0, 16'd0);
		drain();
		write_seg(5'd5, 5'd6);
		add_cmd(npg_pkg::CMD_ADVANCE, 4'd0, 16'd0);
		drain();
		write_seg(5'd16, 5'd0);
		add_cmd(npg_pkg::CMD_ADVANCE, 4'd0, 16'd0);
		drain();
		write_seg(5'd0, 5'd16);
		random_phase(150);
		// hold the sender until everything has drained
		while (pending_cmds.size() > 0 || in_valid) @(posedge clk);
		holding = 1;
		while (expected_elems.size() > 0) @(posedge clk);
		holding = 0;
		drain();
		write_seg(5'd10, 5'd16);
		random_phase(150);
		drain();
		write_seg(5'd3, 5'd9);
		random_phase(100);
		drain();
		write_seg(5'd14, 5'd16);
		random_phase(60);
		drain();
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
